[hdl/cfdd_pkg.sv]
// shared types and constants for the complex fir decimator and derotator
// no dependencies
`default_nettype none

package cfdd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ACC_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CFG_CNT_W  = 7;
   localparam int DECIM_W    = 6;
   localparam int COEFF_IDX_W = 6;
   localparam int DECIM_MAX  = 64;
   localparam int ROT_STEP_W = 4;
   localparam int ROT_LAST   = 8;

   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECIMATION    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP_RE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP_IM = 2'd3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEFF  = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } cplx_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD_LEFT,
      CELL_LOAD_RIGHT
   } cell_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FWD,
      ST_BACK,
      ST_WAIT,
      ST_FIN,
      ST_ROT,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

[hdl/complex_fir_decimator_derotator.sv]
// top level: sample window as a chain of cells, coefficient ram, complex mac
// and derotator; depends on cfdd_pkg, cfdd_ram, cfdd_cell, cfdd_rot
`default_nettype none

// channel   ports                               handshake
// req       req_op, req_sample_*, req_coeff_*   req_valid / req_stall
// rsp       rsp_out_re, rsp_out_im              rsp_valid / rsp_stall
// csr       csr_index, csr_wdata                csr_write
//
// a sample that yields no output and a coefficient write are taken without a stall.
// for an output the window rotates through the mac and back, then the result is
// derotated if enabled; the rotator shares one multiplier.
// req_stall is high while an output is computed or waits for rsp_stall to drop.
// reset is synchronous; coefficients are undefined until written.

module complex_fir_decimator_derotator #(
   parameter int MAX_TAPS   = 64,
   parameter int FRAC_SHIFT = 14
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_op,
   input  wire logic signed [cfdd_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  wire logic signed [cfdd_pkg::SAMPLE_W-1:0]  req_sample_im,
   input  wire logic [cfdd_pkg::COEFF_IDX_W-1:0]      req_coeff_index,
   input  wire logic signed [cfdd_pkg::SAMPLE_W-1:0]  req_coeff_re,
   input  wire logic signed [cfdd_pkg::SAMPLE_W-1:0]  req_coeff_im,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [cfdd_pkg::SAMPLE_W-1:0]       rsp_out_re,
   output logic signed [cfdd_pkg::SAMPLE_W-1:0]       rsp_out_im,
   input  wire logic                                  csr_write,
   input  wire logic [cfdd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [cfdd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W = $clog2(MAX_TAPS + 1);
   localparam int AW    = cfdd_pkg::ACC_W;
   localparam int SW    = cfdd_pkg::SAMPLE_W;

   // configuration
   logic [cfdd_pkg::CFG_CNT_W-1:0] tap_count_ff, decimation_ff;
   logic signed [SW-1:0]           phase_step_re_ff, phase_step_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= cfdd_pkg::CFG_CNT_W'(64);
         decimation_ff    <= cfdd_pkg::CFG_CNT_W'(1);
         phase_step_re_ff <= '0;
         phase_step_im_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            cfdd_pkg::REG_TAP_COUNT:
               tap_count_ff <= csr_wdata[cfdd_pkg::CFG_CNT_W-1:0];
            cfdd_pkg::REG_DECIMATION:
               decimation_ff <= csr_wdata[cfdd_pkg::CFG_CNT_W-1:0];
            cfdd_pkg::REG_PHASE_STEP_RE:
               phase_step_re_ff <= csr_wdata;
            cfdd_pkg::REG_PHASE_STEP_IM:
               phase_step_im_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0]             taps;
   logic [cfdd_pkg::DECIM_W-1:0] dec_m1;
   logic                         rot_en;

   always_comb begin
      if (tap_count_ff == '0) begin
         taps = CNT_W'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         taps = CNT_W'(MAX_TAPS);
      end else begin
         taps = CNT_W'(32'(tap_count_ff));
      end
      if (decimation_ff == '0) begin
         dec_m1 = '0;
      end else if (32'(decimation_ff) > cfdd_pkg::DECIM_MAX) begin
         dec_m1 = cfdd_pkg::DECIM_W'(cfdd_pkg::DECIM_MAX - 1);
      end else begin
         dec_m1 = cfdd_pkg::DECIM_W'(decimation_ff - 1'b1);
      end
      rot_en = (phase_step_re_ff != '0) && (phase_step_im_ff != '0);
   end

   // control
   cfdd_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]             fill_ff, fill_in, step_ff, step_in;
   logic [cfdd_pkg::DECIM_W-1:0] decim_ff, decim_in;
   cfdd_pkg::cell_mode_type      cell_mode;
   logic                         req_take, coeff_wr, issue, clear_acc, rot_start;
   logic                         rsp_load;
   logic [CNT_W-1:0]             fill_next;
   logic [IDX_W-1:0]             rd_addr;
   logic                         rot_done;

   assign req_take  = req_valid && (state_ff == cfdd_pkg::ST_IDLE);
   assign fill_next = (32'(fill_ff) < MAX_TAPS) ? fill_ff + 1'b1 : fill_ff;
   assign rd_addr   = IDX_W'(32'(taps) - 32'(step_ff) - 1);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      step_in   = step_ff;
      decim_in  = decim_ff;
      cell_mode = cfdd_pkg::CELL_HOLD;
      coeff_wr  = 1'b0;
      issue     = 1'b0;
      clear_acc = 1'b0;
      rot_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         cfdd_pkg::ST_IDLE: begin
            if (req_take && req_op == cfdd_pkg::OP_COEFF) begin
               coeff_wr = (32'(req_coeff_index) < MAX_TAPS);
            end else if (req_take) begin
               cell_mode = cfdd_pkg::CELL_LOAD_LEFT;
               fill_in   = fill_next;
               if (fill_next >= taps) begin
                  if (decim_ff != '0) begin
                     decim_in = decim_ff - 1'b1;
                  end else begin
                     decim_in  = dec_m1;
                     clear_acc = 1'b1;
                     step_in   = '0;
                     state_in  = cfdd_pkg::ST_FWD;
                  end
               end
            end
         end
         cfdd_pkg::ST_FWD: begin
            issue     = 1'b1;
            cell_mode = cfdd_pkg::CELL_LOAD_RIGHT;
            if (step_ff == taps - 1'b1) begin
               step_in  = '0;
               state_in = cfdd_pkg::ST_BACK;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         cfdd_pkg::ST_BACK: begin
            cell_mode = cfdd_pkg::CELL_LOAD_LEFT;
            if (step_ff == taps - 1'b1) begin
               step_in  = '0;
               state_in = cfdd_pkg::ST_WAIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         cfdd_pkg::ST_WAIT: begin
            state_in = cfdd_pkg::ST_FIN;
         end
         cfdd_pkg::ST_FIN: begin
            if (rot_en) begin
               rot_start = 1'b1;
               state_in  = cfdd_pkg::ST_ROT;
            end else begin
               state_in = cfdd_pkg::ST_OUT;
            end
         end
         cfdd_pkg::ST_ROT: begin
            if (rot_done) begin
               state_in = cfdd_pkg::ST_OUT;
            end
         end
         cfdd_pkg::ST_OUT: begin
            if (!rsp_valid || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = cfdd_pkg::ST_IDLE;
            end
         end
         default: state_in = cfdd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfdd_pkg::ST_IDLE;
         fill_ff  <= '0;
         step_ff  <= '0;
         decim_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         step_ff  <= step_in;
         decim_ff <= decim_in;
      end
   end

   assign req_stall = (state_ff != cfdd_pkg::ST_IDLE);

   // sample window
   cfdd_pkg::cplx_type cell_data [MAX_TAPS];
   cfdd_pkg::cplx_type sample_in, head_left;

   assign sample_in.re = req_sample_re;
   assign sample_in.im = req_sample_im;
   assign head_left    = (state_ff == cfdd_pkg::ST_BACK) ? cell_data[MAX_TAPS-1] : sample_in;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      cfdd_cell u_cell (
         .clock    (clock),
         .mode     (cell_mode),
         .left_in  ((k == 0) ? head_left : cell_data[(k == 0) ? 0 : k-1]),
         .right_in ((k == MAX_TAPS-1) ? cell_data[0] : cell_data[(k == MAX_TAPS-1) ? k : k+1]),
         .data     (cell_data[k])
      );
   end

   // coefficient table
   logic [2*SW-1:0]    coeff_rd;
   cfdd_pkg::cplx_type coeff_wdata, coeff_q;

   assign coeff_wdata.re = req_coeff_re;
   assign coeff_wdata.im = req_coeff_im;
   assign coeff_q        = coeff_rd;

   cfdd_ram #(
      .WIDTH (2*SW),
      .DEPTH (MAX_TAPS)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (coeff_wr),
      .wr_addr (IDX_W'(32'(req_coeff_index))),
      .wr_data (coeff_wdata),
      .rd_addr (rd_addr),
      .rd_data (coeff_rd)
   );

   // complex mac
   cfdd_pkg::cplx_type samp_d_ff;
   logic               v1_ff, v2_ff;
   logic signed [AW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [AW-1:0]      acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (clear_acc) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (v2_ff) begin
         acc_re_in = acc_re_ff + AW'(p_rr_ff) - AW'(p_ii_ff);
         acc_im_in = acc_im_ff + AW'(p_ri_ff) + AW'(p_ir_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
      samp_d_ff <= cell_data[0];
      p_rr_ff   <= coeff_q.re * samp_d_ff.re;
      p_ii_ff   <= coeff_q.im * samp_d_ff.im;
      p_ri_ff   <= coeff_q.re * samp_d_ff.im;
      p_ir_ff   <= coeff_q.im * samp_d_ff.re;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   // derotation
   logic [AW-1:0] rot_re, rot_im, fin_re, fin_im;

   cfdd_rot #(
      .FRAC_SHIFT (FRAC_SHIFT)
   ) u_rot (
      .clock   (clock),
      .reset   (reset),
      .start   (rot_start),
      .acc_re  (acc_re_ff),
      .acc_im  (acc_im_ff),
      .step_re (phase_step_re_ff),
      .step_im (phase_step_im_ff),
      .done    (rot_done),
      .res_re  (rot_re),
      .res_im  (rot_im)
   );

   assign fin_re = rot_en ? rot_re : acc_re_ff;
   assign fin_im = rot_en ? rot_im : acc_im_ff;

   // output register
   logic                 rsp_valid_ff;
   logic signed [SW-1:0] out_re_ff, out_im_ff;
   logic [AW-1:0]        sh_re, sh_im;

   assign sh_re = AW'($signed(fin_re) >>> FRAC_SHIFT);
   assign sh_im = AW'($signed(fin_im) >>> FRAC_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         out_re_ff <= sh_re[SW-1:0];
         out_im_ff <= sh_im[SW-1:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_re = out_re_ff;
   assign rsp_out_im = out_im_ff;

endmodule

`default_nettype wire

[hdl/cfdd_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cfdd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/cfdd_cell.sv]
// one window cell: holds a complex sample, loads from either neighbor
// depends on cfdd_pkg
`default_nettype none

module cfdd_cell (
   input  wire logic                    clock,
   input  wire cfdd_pkg::cell_mode_type mode,
   input  wire cfdd_pkg::cplx_type      left_in,
   input  wire cfdd_pkg::cplx_type      right_in,
   output cfdd_pkg::cplx_type           data
);

   cfdd_pkg::cplx_type data_ff;
   cfdd_pkg::cplx_type data_in;

   always_comb begin
      case (mode)
         cfdd_pkg::CELL_LOAD_LEFT:  data_in = left_in;
         cfdd_pkg::CELL_LOAD_RIGHT: data_in = right_in;
         default:                   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[hdl/cfdd_rot.sv]
// derotator: one shared 32x32 multiplier sequenced over eight products,
// holds the phasor; depends on cfdd_pkg
`default_nettype none

module cfdd_rot #(
   parameter int FRAC_SHIFT = 14
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [cfdd_pkg::ACC_W-1:0]         acc_re,
   input  wire logic [cfdd_pkg::ACC_W-1:0]         acc_im,
   input  wire logic signed [cfdd_pkg::SAMPLE_W-1:0] step_re,
   input  wire logic signed [cfdd_pkg::SAMPLE_W-1:0] step_im,
   output logic                                    done,
   output logic [cfdd_pkg::ACC_W-1:0]              res_re,
   output logic [cfdd_pkg::ACC_W-1:0]              res_im
);

   localparam int W = cfdd_pkg::ACC_W;

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [cfdd_pkg::ROT_STEP_W-1:0]  step_ff, step_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [W-1:0] r_re_ff, r_re_in, r_im_ff, r_im_in;
   logic [W-1:0] n_re_ff, n_re_in, n_im_ff, n_im_in;
   logic [W-1:0] ph_re_ff, ph_re_in, ph_im_ff, ph_im_in;
   logic [W-1:0] a_re, a_im, inc_re, inc_im, op_a, op_b, n_im_last;

   always_comb begin
      a_re   = W'($signed(acc_re) >>> FRAC_SHIFT);
      a_im   = W'($signed(acc_im) >>> FRAC_SHIFT);
      inc_re = W'(step_re);
      inc_im = W'(step_im);
      case (step_ff)
         4'd0:    begin op_a = a_re;     op_b = ph_re_ff; end
         4'd1:    begin op_a = a_im;     op_b = ph_im_ff; end
         4'd2:    begin op_a = a_re;     op_b = ph_im_ff; end
         4'd3:    begin op_a = a_im;     op_b = ph_re_ff; end
         4'd4:    begin op_a = ph_re_ff; op_b = inc_re;   end
         4'd5:    begin op_a = ph_im_ff; op_b = inc_im;   end
         4'd6:    begin op_a = ph_im_ff; op_b = inc_re;   end
         4'd7:    begin op_a = ph_re_ff; op_b = inc_im;   end
         default: begin op_a = '0;       op_b = '0;       end
      endcase
      n_im_last = n_im_ff + prod_ff;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      prod_in  = prod_ff;
      r_re_in  = r_re_ff;
      r_im_in  = r_im_ff;
      n_re_in  = n_re_ff;
      n_im_in  = n_im_ff;
      ph_re_in = ph_re_ff;
      ph_im_in = ph_im_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         r_re_in = '0;
         r_im_in = '0;
         n_re_in = '0;
         n_im_in = '0;
      end else if (busy_ff) begin
         prod_in = op_a * op_b;
         step_in = step_ff + 1'b1;
         case (step_ff)
            4'd1: r_re_in = r_re_ff + prod_ff;
            4'd2: r_re_in = r_re_ff - prod_ff;
            4'd3: r_im_in = r_im_ff + prod_ff;
            4'd4: r_im_in = r_im_ff + prod_ff;
            4'd5: n_re_in = n_re_ff + prod_ff;
            4'd6: n_re_in = n_re_ff - prod_ff;
            4'd7: n_im_in = n_im_ff + prod_ff;
            default: ;
         endcase
         if (step_ff == cfdd_pkg::ROT_STEP_W'(cfdd_pkg::ROT_LAST)) begin
            n_im_in  = n_im_last;
            ph_re_in = W'($signed(n_re_ff) >>> FRAC_SHIFT);
            ph_im_in = W'($signed(n_im_last) >>> FRAC_SHIFT);
            busy_in  = 1'b0;
            done_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
         ph_re_ff <= W'(1) << FRAC_SHIFT;
         ph_im_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
         ph_re_ff <= ph_re_in;
         ph_im_ff <= ph_im_in;
      end
      prod_ff <= prod_in;
      r_re_ff <= r_re_in;
      r_im_ff <= r_im_in;
      n_re_ff <= n_re_in;
      n_im_ff <= n_im_in;
   end

   assign done   = done_ff;
   assign res_re = r_re_ff;
   assign res_im = r_im_ff;

endmodule

`default_nettype wire

[verif/tb.sv]
// self-checking testbench for complex_fir_decimator_derotator: directed table, then random
// sample and coefficient items over several register settings; depends on cfdd_pkg
`default_nettype none

module tb;

   localparam int FRAC_SHIFT = 14;

   typedef struct {
      logic                                 op;
      logic signed [cfdd_pkg::SAMPLE_W-1:0] s_re;
      logic signed [cfdd_pkg::SAMPLE_W-1:0] s_im;
      logic [cfdd_pkg::COEFF_IDX_W-1:0]     idx;
      logic signed [cfdd_pkg::SAMPLE_W-1:0] c_re;
      logic signed [cfdd_pkg::SAMPLE_W-1:0] c_im;
      bit                                   typed;
      logic signed [cfdd_pkg::SAMPLE_W-1:0] e_re;
      logic signed [cfdd_pkg::SAMPLE_W-1:0] e_im;
   } fir_item_type;

   typedef struct {
      logic signed [cfdd_pkg::SAMPLE_W-1:0] re;
      logic signed [cfdd_pkg::SAMPLE_W-1:0] im;
   } fir_out_type;

   logic clock, reset;
   logic req_valid, req_stall, req_op;
   logic signed [cfdd_pkg::SAMPLE_W-1:0] req_sample_re, req_sample_im;
   logic signed [cfdd_pkg::SAMPLE_W-1:0] req_coeff_re, req_coeff_im;
   logic [cfdd_pkg::COEFF_IDX_W-1:0] req_coeff_index;
   logic rsp_valid, rsp_stall;
   logic signed [cfdd_pkg::SAMPLE_W-1:0] rsp_out_re, rsp_out_im;
   logic csr_write;
   logic [cfdd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cfdd_pkg::CSR_DATA_W-1:0] csr_wdata;

   complex_fir_decimator_derotator u_dut (.*);

   // filter model state
   logic signed [cfdd_pkg::SAMPLE_W-1:0] coef_re [64];
   logic signed [cfdd_pkg::SAMPLE_W-1:0] coef_im [64];
   logic signed [cfdd_pkg::SAMPLE_W-1:0] win_re [64];
   logic signed [cfdd_pkg::SAMPLE_W-1:0] win_im [64];
   int unsigned fill_cnt, decim_cnt;
   logic signed [31:0] rot_re, rot_im;
   logic [6:0] cfg_taps, cfg_decim;
   logic signed [15:0] cfg_step_re, cfg_step_im;

   fir_out_type expected_q[$];
   fir_item_type dir_rows[$];
   int errors = 0, outputs = 0, items = 0, phase_outs = 0;
   bit no_idle = 0;
   int hold_cnt = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bit filter_sample(logic signed [15:0] s_re, logic signed [15:0] s_im,
                                        output fir_out_type res);
      int unsigned taps, dec;
      logic signed [31:0] acc_re, acc_im, a_re, a_im, n_re, n_im;
      acc_re = 0;
      acc_im = 0;
      for (int i = 63; i > 0; i--) begin
         win_re[i] = win_re[i-1];
         win_im[i] = win_im[i-1];
      end
      win_re[0] = s_re;
      win_im[0] = s_im;
      if (fill_cnt < 64) fill_cnt++;
      taps = (cfg_taps == 0) ? 1 : (cfg_taps > 64) ? 64 : cfg_taps;
      dec = (cfg_decim == 0) ? 1 : (cfg_decim > 64) ? 64 : cfg_decim;
      if (fill_cnt < taps) return 0;
      if (decim_cnt != 0) begin
         decim_cnt = (decim_cnt - 1) & 6'h3f;
         return 0;
      end
      decim_cnt = (dec - 1) & 6'h3f;
      for (int i = 0; i < taps; i++) begin
         acc_re += 32'(coef_re[i] * win_re[taps-1-i]) - 32'(coef_im[i] * win_im[taps-1-i]);
         acc_im += 32'(coef_re[i] * win_im[taps-1-i]) + 32'(coef_im[i] * win_re[taps-1-i]);
      end
      if (cfg_step_re != 0 && cfg_step_im != 0) begin
         a_re = acc_re >>> FRAC_SHIFT;
         a_im = acc_im >>> FRAC_SHIFT;
         acc_re = a_re * rot_re - a_im * rot_im;
         acc_im = a_re * rot_im + a_im * rot_re;
         n_re = rot_re * 32'(cfg_step_re) - rot_im * 32'(cfg_step_im);
         n_im = rot_im * 32'(cfg_step_re) + rot_re * 32'(cfg_step_im);
         rot_re = n_re >>> FRAC_SHIFT;
         rot_im = n_im >>> FRAC_SHIFT;
      end
      acc_re = acc_re >>> FRAC_SHIFT;
      acc_im = acc_im >>> FRAC_SHIFT;
      res.re = acc_re[15:0];
      res.im = acc_im[15:0];
      return 1;
   endfunction

   task automatic send_item(fir_item_type it);
      int gap;
      fir_out_type res;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_sample_re <= it.s_re;
      req_sample_im <= it.s_im;
      req_coeff_index <= it.idx;
      req_coeff_re <= it.c_re;
      req_coeff_im <= it.c_im;
      do @(posedge clock); while (req_stall);
      items++;
      if (it.op == cfdd_pkg::OP_COEFF) begin
         coef_re[it.idx] = it.c_re;
         coef_im[it.idx] = it.c_im;
      end else if (filter_sample(it.s_re, it.s_im, res)) begin
         if (it.typed) begin
            res.re = it.e_re;
            res.im = it.e_im;
         end
         expected_q.push_back(res);
         phase_outs++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic apply_setting(logic [6:0] taps, logic [6:0] dec,
                                logic signed [15:0] st_re, logic signed [15:0] st_im);
      csr_write <= 1'b1;
      csr_index <= cfdd_pkg::REG_TAP_COUNT;
      csr_wdata <= 16'(taps);
      @(posedge clock);
      csr_index <= cfdd_pkg::REG_DECIMATION;
      csr_wdata <= 16'(dec);
      @(posedge clock);
      csr_index <= cfdd_pkg::REG_PHASE_STEP_RE;
      csr_wdata <= st_re;
      @(posedge clock);
      csr_index <= cfdd_pkg::REG_PHASE_STEP_IM;
      csr_wdata <= st_im;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_taps = taps;
      cfg_decim = dec;
      cfg_step_re = st_re;
      cfg_step_im = st_im;
   endtask

   function automatic fir_item_type make_row(logic op, int a, int b, int idx, bit typed,
                                             int e_re, int e_im);
      fir_item_type r;
      r.op = op;
      r.s_re = (op == cfdd_pkg::OP_SAMPLE) ? 16'(a) : 16'($urandom);
      r.s_im = (op == cfdd_pkg::OP_SAMPLE) ? 16'(b) : 16'($urandom);
      r.c_re = (op == cfdd_pkg::OP_COEFF) ? 16'(a) : 16'($urandom);
      r.c_im = (op == cfdd_pkg::OP_COEFF) ? 16'(b) : 16'($urandom);
      r.idx = (op == cfdd_pkg::OP_COEFF) ? 6'(idx) : 6'($urandom);
      r.typed = typed;
      r.e_re = 16'(e_re);
      r.e_im = 16'(e_im);
      return r;
   endfunction

   // result checker with random stall
   always @(posedge clock) begin
      fir_out_type exp_out;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            outputs++;
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item: re %0d im %0d", rsp_out_re, rsp_out_im);
            end else begin
               exp_out = expected_q.pop_front();
               if (rsp_out_re !== exp_out.re || rsp_out_im !== exp_out.im) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected re %0d im %0d, got re %0d im %0d",
                              exp_out.re, exp_out.im, rsp_out_re, rsp_out_im);
               end
            end
            hold_cnt = no_idle ? 0 : $urandom_range(0, 8);
         end else if (hold_cnt > 0) begin
            hold_cnt--;
         end
         rsp_stall <= (hold_cnt > 0);
      end
   end

   initial begin
      fir_item_type it;
      int settings [10][4] = '{
         '{4, 1, 0, 0}, '{16, 4, 16384, 16384}, '{64, 64, -16384, -16384},
         '{1, 64, 16384, -16384}, '{0, 0, 5000, -3000}, '{127, 127, 16384, 0},
         '{8, 2, 15000, 7000}, '{32, 3, -32768, 32767}, '{5, 1, 0, 16384},
         '{64, 1, 16384, 1}};
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = cfdd_pkg::OP_SAMPLE;
      req_sample_re = '0;
      req_sample_im = '0;
      req_coeff_index = '0;
      req_coeff_re = '0;
      req_coeff_im = '0;
      csr_write = 1'b0;
      csr_index = cfdd_pkg::REG_TAP_COUNT;
      csr_wdata = '0;
      fill_cnt = 0;
      decim_cnt = 0;
      rot_re = 32'sd16384;
      rot_im = 0;
      cfg_taps = 64;
      cfg_decim = 1;
      cfg_step_re = 0;
      cfg_step_im = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single tap, no decimation, no rotation
      apply_setting(7'd1, 7'd1, 16'sd0, 16'sd0);
      dir_rows.push_back(make_row(cfdd_pkg::OP_COEFF, 16384, 0, 0, 0, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, 32767, -32768, 0, 1, 32767, -32768));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, -32768, 32767, 0, 1, -32768, 32767));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, 0, 0, 0, 1, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_COEFF, 0, 16384, 0, 0, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, 100, 200, 0, 1, -200, 100));
      dir_rows.push_back(make_row(cfdd_pkg::OP_COEFF, -32768, 32767, 63, 0, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_COEFF, -32768, -32768, 0, 0, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, -32768, -32768, 0, 1, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_COEFF, 32767, 32767, 0, 0, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, 32767, 32767, 0, 0, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, 1, -1, 0, 0, 0, 0));
      dir_rows.push_back(make_row(cfdd_pkg::OP_SAMPLE, -1, 1, 0, 0, 0, 0));
      foreach (dir_rows[i]) send_item(dir_rows[i]);

      // fill the whole coefficient table before wider filters
      for (int i = 0; i < 64; i++)
         send_item(make_row(cfdd_pkg::OP_COEFF, $urandom, $urandom, i, 0, 0, 0));
      drain();

      foreach (settings[p]) begin
         apply_setting(7'(settings[p][0]), 7'(settings[p][1]),
                       16'(settings[p][2]), 16'(settings[p][3]));
         no_idle = (p % 4 == 2);
         phase_outs = 0;
         for (int n = 0; n < 65 || phase_outs < 2; n++) begin
            if (p == 3 && n == 30) drain();
            if ($urandom_range(0, 7) == 0)
               it = make_row(cfdd_pkg::OP_COEFF, $urandom, $urandom,
                             $urandom_range(0, 63), 0, 0, 0);
            else if ($urandom_range(0, 15) == 0)
               it = make_row(cfdd_pkg::OP_SAMPLE, $urandom_range(0, 1) ? 32767 : -32768,
                             $urandom_range(0, 1) ? 32767 : -32768, 0, 0, 0, 0);
            else
               it = make_row(cfdd_pkg::OP_SAMPLE, $urandom, $urandom, 0, 0, 0, 0);
            send_item(it);
         end
         drain();
      end

      $display("covered %0d input items and %0d outputs over %0d register settings",
               items, outputs, 11);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
